@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL of the buzzer tone sequencer.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: invariant");

`endif

@@ hw/rtl/bts_pkg.sv @@
// Package for the buzzer tone sequencer: codes, widths and constants.
// No dependencies; imported by bts_div, buzzer_tone_sequencer and the testbench.
`default_nettype none

package bts_pkg;

  // Note store
  localparam int NOTE_DEPTH = 256;
  localparam int NOTE_AW    = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;

  // Field widths
  localparam int OP_W   = 3;
  localparam int FREQ_W = 16;
  localparam int DUR_W  = 8;
  localparam int SLOT_W = 8;
  localparam int RLD_W  = 9;
  localparam int CMP_W  = 8;
  localparam int CNT_W  = 9;

  // Tone math: quotient = 48000 / f, one dividend bit per cycle
  localparam int DVD_W  = 16;
  localparam int DSR_W  = 13;   // f <= 6000
  localparam int QUO_W  = 9;    // quotient <= 480
  localparam int STEP_W = $clog2(DVD_W + 1);

  localparam logic [DVD_W-1:0]  TONE_CLK_HZ = 16'd48000;
  localparam logic [FREQ_W-1:0] FREQ_MIN    = 16'd100;
  localparam logic [FREQ_W-1:0] FREQ_MAX    = 16'd6000;
  localparam logic [RLD_W-1:0]  RELOAD_RST  = 9'd47;
  localparam logic [CMP_W-1:0]  COMPARE_RST = 8'd24;
  localparam logic [CNT_W-1:0]  CNT_SAT     = '1;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_SINGLE = 3'd1,
    OP_SEQ    = 3'd2,
    OP_MUTE   = 3'd3,
    OP_UNMUTE = 3'd4,
    OP_WRITE  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_SINGLE = 2'd1,
    MODE_SEQ    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_MAIN  = 2'd1,
    PH_STOP  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [DUR_W-1:0]  dur;
    logic [FREQ_W-1:0] freq;
  } note_t;

  // Divider handshake
  typedef struct packed {
    logic             start;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic tone_ok(input logic [FREQ_W-1:0] f);
    tone_ok = (f >= FREQ_MIN) && (f <= FREQ_MAX);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bts_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies; holds the note store of the buzzer tone sequencer.
`default_nettype none

module bts_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/bts_div.sv @@
// Bit-serial restoring divider: 48000 / f, one dividend bit per cycle.
// Depends on bts_pkg.
`default_nettype none

module bts_div
  import bts_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [DSR_W-1:0]  dsr_r, dsr_nxt;
  logic [DSR_W-1:0]  rem_r, rem_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [DSR_W:0]    trial;
  logic [DSR_W:0]    diff;
  logic              qbit;

  // shift in next dividend bit, try subtract
  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign qbit  = (trial >= {1'b0, dsr_r});

  always_comb begin
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dvd_nxt  = TONE_CLK_HZ;
      dsr_nxt  = req.divisor;
      rem_nxt  = '0;
      quo_nxt  = '0;
      step_nxt = STEP_W'(DVD_W);
      run_nxt  = 1'b1;
    end else if (run_r) begin
      dvd_nxt  = {dvd_r[DVD_W-2:0], 1'b0};
      rem_nxt  = qbit ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      quo_nxt  = {quo_r[QUO_W-2:0], qbit};
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (!rst_n) begin
      step_r <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.busy     = run_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

@@ hw/rtl/buzzer_tone_sequencer.sv @@
// Buzzer tone sequencer top level: command decode, play sequencer, note store.
// Path: IDLE takes the item and OUT presents the result; a tone change adds DIV (16-step
//   serial divider), and a stored note also passes through READ for the note store RAM.
// Flow: one transaction in flight; a new item is taken only after the last result is taken.
// Reset: synchronous, active low; clears control and play state, PWM values to 47/24.
//   The note store is not cleared; a slot reads undefined until it is written.
`default_nettype none

`include "assert_macros.svh"

module buzzer_tone_sequencer
  import bts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [OP_W-1:0]   in_operation,
  input  wire logic [FREQ_W-1:0] in_freq_hz,
  input  wire logic [DUR_W-1:0]  in_duration_ticks,
  input  wire logic [SLOT_W-1:0] in_note_slot,
  input  wire logic [SLOT_W-1:0] in_final_slot,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_tone_on,
  output logic      [RLD_W-1:0]  out_period_reload,
  output logic      [CMP_W-1:0]  out_duty_compare,
  output logic                   out_is_muted,
  output logic      [1:0]        out_play_state
);

  // Control flow: IDLE takes one transaction, READ waits on the note store,
  // DIV waits on the divider, OUT holds the result until it is taken.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t             state_r, state_nxt;
  mode_t              mode_r, mode_nxt;
  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DUR_W-1:0]   dur_r, dur_nxt;
  logic [SLOT_W-1:0]  pos_r, pos_nxt;
  logic [NOTE_AW-1:0] addr_r, addr_nxt;     // pos_r modulo NOTE_DEPTH
  logic [SLOT_W-1:0]  last_r, last_nxt;
  logic               muted_r, muted_nxt;
  logic               oe_r, oe_nxt;
  logic [RLD_W-1:0]   reload_r, reload_nxt;
  logic [CMP_W-1:0]   compare_r, compare_nxt;

  logic               in_fire;
  logic               need_load;
  logic [CNT_W-1:0]   cnt_inc;
  logic [NOTE_AW-1:0] addr_inc;
  note_t              rd_note;
  logic [3*DUR_W-1:0] rd_word;
  logic               ram_we;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;

  // saturating tick counter and wrapping store address
  assign cnt_inc  = (cnt_r == CNT_SAT) ? cnt_r : cnt_r + CNT_W'(1);
  assign addr_inc = (addr_r == NOTE_AW'(NOTE_DEPTH - 1)) ? '0 : addr_r + NOTE_AW'(1);

  // Note store: written by write-note, read at the next play address.
  // The read port follows addr_nxt so the entry lands in the READ cycle.
  assign ram_we  = in_fire && (op_t'(in_operation) == OP_WRITE) &&
                   ({1'b0, in_note_slot} < (SLOT_W + 1)'(NOTE_DEPTH));
  assign rd_note = note_t'(rd_word);

  bts_ram #(
    .WIDTH (3 * DUR_W),
    .DEPTH (NOTE_DEPTH),
    .AW    (NOTE_AW)
  ) u_note_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_note_slot[NOTE_AW-1:0]),
    .wdata ({in_duration_ticks, in_freq_hz}),
    .raddr (addr_nxt),
    .rdata (rd_word)
  );

  bts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    dur_nxt     = dur_r;
    pos_nxt     = pos_r;
    addr_nxt    = addr_r;
    last_nxt    = last_r;
    muted_nxt   = muted_r;
    oe_nxt      = oe_r;
    reload_nxt  = reload_r;
    compare_nxt = compare_r;
    need_load   = 1'b0;
    div_req     = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (op_t'(in_operation))
            OP_TICK: begin
              // ticks are frozen while muted
              if (!muted_r && mode_r == MODE_SINGLE) begin
                case (phase_r)
                  PH_START: begin
                    cnt_nxt   = '0;
                    oe_nxt    = 1'b1;
                    phase_nxt = PH_MAIN;
                  end
                  PH_MAIN: begin
                    cnt_nxt = cnt_inc;
                    if (cnt_inc > CNT_W'(dur_r)) begin
                      phase_nxt = PH_STOP;
                    end
                  end
                  default: begin
                    oe_nxt   = 1'b0;
                    mode_nxt = MODE_IDLE;
                  end
                endcase
              end else if (!muted_r && mode_r == MODE_SEQ) begin
                case (phase_r)
                  PH_START: begin
                    pos_nxt   = '0;
                    addr_nxt  = '0;
                    cnt_nxt   = '0;
                    oe_nxt    = 1'b1;
                    phase_nxt = PH_MAIN;
                    need_load = 1'b1;
                  end
                  PH_MAIN: begin
                    cnt_nxt = cnt_inc;
                    if (cnt_inc >= CNT_W'(dur_r)) begin
                      if (pos_r < last_r) begin
                        pos_nxt   = pos_r + SLOT_W'(1);
                        addr_nxt  = addr_inc;
                        cnt_nxt   = '0;
                        need_load = 1'b1;
                      end else begin
                        oe_nxt    = 1'b0;
                        phase_nxt = PH_STOP;
                      end
                    end
                  end
                  default: begin
                    mode_nxt = MODE_IDLE;
                  end
                endcase
              end
            end
            OP_SINGLE: begin
              dur_nxt   = in_duration_ticks;
              mode_nxt  = MODE_SINGLE;
              phase_nxt = PH_START;
              if (tone_ok(in_freq_hz)) begin
                div_req.start   = 1'b1;
                div_req.divisor = in_freq_hz[DSR_W-1:0];
              end
            end
            OP_SEQ: begin
              last_nxt  = in_final_slot;
              mode_nxt  = MODE_SEQ;
              phase_nxt = PH_START;
            end
            OP_MUTE: begin
              oe_nxt    = 1'b0;
              muted_nxt = 1'b1;
            end
            OP_UNMUTE: begin
              muted_nxt = 1'b0;
            end
            default: begin
              // write note handled by the RAM port; unknown codes do nothing
            end
          endcase

          if (need_load) begin
            state_nxt = ST_READ;
          end else if (div_req.start) begin
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end

      ST_READ: begin
        dur_nxt = rd_note.dur;
        if (tone_ok(rd_note.freq)) begin
          div_req.start   = 1'b1;
          div_req.divisor = rd_note.freq[DSR_W-1:0];
          state_nxt       = ST_DIV;
        end else begin
          state_nxt = ST_OUT;
        end
      end

      ST_DIV: begin
        if (div_rsp.done) begin
          reload_nxt  = div_rsp.quotient - RLD_W'(1);
          compare_nxt = div_rsp.quotient[QUO_W-1:1];
          state_nxt   = ST_OUT;
        end
      end

      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mode_r    <= MODE_IDLE;
      phase_r   <= PH_START;
      cnt_r     <= '0;
      dur_r     <= '0;
      pos_r     <= '0;
      addr_r    <= '0;
      last_r    <= '0;
      muted_r   <= 1'b0;
      oe_r      <= 1'b0;
      reload_r  <= RELOAD_RST;
      compare_r <= COMPARE_RST;
    end else begin
      state_r   <= state_nxt;
      mode_r    <= mode_nxt;
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      dur_r     <= dur_nxt;
      pos_r     <= pos_nxt;
      addr_r    <= addr_nxt;
      last_r    <= last_nxt;
      muted_r   <= muted_nxt;
      oe_r      <= oe_nxt;
      reload_r  <= reload_nxt;
      compare_r <= compare_nxt;
    end
  end

  // Result transaction shows the state after the item; it holds still while pending in OUT.
  assign out_valid         = (state_r == ST_OUT);
  assign out_tone_on       = oe_r;
  assign out_period_reload = reload_r;
  assign out_duty_compare  = compare_r;
  assign out_is_muted      = muted_r;
  assign out_play_state    = mode_r;

  // A new transaction is never taken while a result is pending.
  `ASSERT_IMPLIES(a_no_accept_pending, clk, rst_n, in_valid && !in_stall, !out_valid)
  // The output only turns on from an unmuted tick, and mute turns it off.
  `ASSERT_ALWAYS(a_on_not_muted, clk, rst_n, !(out_tone_on && out_is_muted))
  // Compare is always half of the PWM period.
  `ASSERT_ALWAYS(a_duty_half, clk, rst_n,
    out_duty_compare == CMP_W'(({1'b0, out_period_reload} + (RLD_W + 1)'(1)) >> 1))
  // The divider only runs while the sequencer waits on it.
  `ASSERT_IMPLIES(a_div_owned, clk, rst_n, div_rsp.busy, state_r == ST_DIV)

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for buzzer_tone_sequencer: directed and random command streams,
// a transaction-level model of the tone player, and field-by-field status checks.
// Depends on bts_pkg and the buzzer_tone_sequencer RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bts_pkg::*;

  // Opcodes the block must ignore
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  localparam int STIM_ITEMS   = 1200;  // commands to generate, spare opcodes aside
  localparam int WATCHDOG     = 3000;  // cycles without any transaction
  localparam int HOLD_CYCLES  = 250;   // one long result hold-off
  localparam int HOLD_AFTER   = 300;   // statuses checked before the hold-off
  localparam int CALM_TAIL    = 120;   // last commands run without idling
  localparam int DRAIN_CYCLES = 40;    // settle time after the last status

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0]  dur;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] fin;
  } cmd_t;

  typedef struct {
    logic             on;
    logic [RLD_W-1:0] reload;
    logic [CMP_W-1:0] compare;
    logic             muted;
    mode_t            play;
  } status_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic              clk               = 1'b0;
  logic              rst_n             = 1'b0;
  logic              in_valid          = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   in_operation      = '0;
  logic [FREQ_W-1:0] in_freq_hz        = '0;
  logic [DUR_W-1:0]  in_duration_ticks = '0;
  logic [SLOT_W-1:0] in_note_slot      = '0;
  logic [SLOT_W-1:0] in_final_slot     = '0;
  logic              out_valid;
  logic              out_stall         = 1'b0;
  logic              out_tone_on;
  logic [RLD_W-1:0]  out_period_reload;
  logic [CMP_W-1:0]  out_duty_compare;
  logic              out_is_muted;
  logic [1:0]        out_play_state;

  always #6 clk = ~clk;

  buzzer_tone_sequencer i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_freq_hz        (in_freq_hz),
    .in_duration_ticks (in_duration_ticks),
    .in_note_slot      (in_note_slot),
    .in_final_slot     (in_final_slot),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tone_on       (out_tone_on),
    .out_period_reload (out_period_reload),
    .out_duty_compare  (out_duty_compare),
    .out_is_muted      (out_is_muted),
    .out_play_state    (out_play_state)
  );

  // --------------------------------------------------------------------------
  // Shared bookkeeping
  // --------------------------------------------------------------------------
  cmd_t    pending[$];      // commands not yet offered to the DUT
  status_t status_due[$];   // predicted statuses, oldest first
  logic    in_taken = 1'b0; // command transaction completed at the last rising edge
  int      idle_run = 0;    // cycles since the last transaction on either channel
  int      errors   = 0;
  int      checked  = 0;
  int      hold_left = 0;
  int      n_tick = 0, n_single = 0, n_seq = 0, n_write = 0, n_misc = 0;

  // Generator view of the note store: which slots hold data, and how long each note is.
  // Sequences never run past the written prefix, so no unwritten slot is ever read.
  bit                filled[NOTE_DEPTH];
  logic [DUR_W-1:0]  stored_len[NOTE_DEPTH];
  int                frontier = 0;
  int                cmds_made = 0;

  // --------------------------------------------------------------------------
  // Tone player model: its own copy of the play state and note store
  // --------------------------------------------------------------------------
  mode_t             pl_mode    = MODE_IDLE;
  phase_t            pl_phase   = PH_START;
  logic [CNT_W-1:0]  pl_count   = '0;
  logic [DUR_W-1:0]  pl_dur     = '0;
  logic [SLOT_W-1:0] pl_pos     = '0;
  logic [SLOT_W-1:0] pl_last    = '0;
  logic              pl_muted   = 1'b0;
  logic              pl_on      = 1'b0;
  logic [RLD_W-1:0]  pl_reload  = RELOAD_RST;
  logic [CMP_W-1:0]  pl_compare = COMPARE_RST;
  note_t             pl_notes[NOTE_DEPTH];

  // Out-of-range frequencies leave the PWM values alone.
  task automatic load_tone(input logic [FREQ_W-1:0] f);
    int unsigned q;
    if (f >= FREQ_MIN && f <= FREQ_MAX) begin
      q          = TONE_CLK_HZ / f;
      pl_reload  = RLD_W'(q - 1);
      pl_compare = CMP_W'(q / 2);
    end
  endtask

  task automatic load_note(input logic [SLOT_W-1:0] pos);
    note_t n;
    n = pl_notes[pos % NOTE_DEPTH];
    load_tone(n.freq);
    pl_dur = n.dur;
  endtask

  // 9-bit count saturates; duration 255 needs it to reach 256
  task automatic bump_count();
    if (pl_count != CNT_SAT) pl_count = pl_count + 1'b1;
  endtask

  // Apply one command to the model and queue the status it must produce.
  task automatic step_player(input cmd_t c);
    case (c.op)
      OP_TICK: begin
        n_tick++;
        // muted or idle: ticks are frozen
        if (!pl_muted && pl_mode == MODE_SINGLE) begin
          case (pl_phase)
            PH_START: begin
              pl_count = '0;
              pl_on    = 1'b1;
              pl_phase = PH_MAIN;
            end
            PH_MAIN: begin
              bump_count();
              if (pl_count > pl_dur) pl_phase = PH_STOP;
            end
            default: begin
              pl_on   = 1'b0;
              pl_mode = MODE_IDLE;
            end
          endcase
        end else if (!pl_muted && pl_mode == MODE_SEQ) begin
          case (pl_phase)
            PH_START: begin
              pl_pos   = '0;
              pl_count = '0;
              load_note(pl_pos);
              pl_on    = 1'b1;
              pl_phase = PH_MAIN;
            end
            PH_MAIN: begin
              bump_count();
              if (pl_count >= pl_dur) begin
                if (pl_pos < pl_last) begin
                  pl_pos   = pl_pos + 1'b1;
                  pl_count = '0;
                  load_note(pl_pos);
                end else begin
                  pl_on    = 1'b0;
                  pl_phase = PH_STOP;
                end
              end
            end
            default: pl_mode = MODE_IDLE;
          endcase
        end
      end
      OP_SINGLE: begin
        n_single++;
        load_tone(c.freq);
        pl_dur   = c.dur;
        pl_mode  = MODE_SINGLE;
        pl_phase = PH_START;
      end
      OP_SEQ: begin
        n_seq++;
        pl_last  = c.fin;
        pl_mode  = MODE_SEQ;
        pl_phase = PH_START;
      end
      OP_MUTE: begin
        n_misc++;
        pl_on    = 1'b0;
        pl_muted = 1'b1;
      end
      OP_UNMUTE: begin
        n_misc++;
        pl_muted = 1'b0;
      end
      OP_WRITE: begin
        n_write++;
        if (c.slot < NOTE_DEPTH) pl_notes[c.slot] = '{dur: c.dur, freq: c.freq};
      end
      default: n_misc++;
    endcase
    status_due.push_back('{pl_on, pl_reload, pl_compare, pl_muted, pl_mode});
  endtask

  task automatic check_field(input string tag, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, tag, want, got);
      errors++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_cmd(input logic [OP_W-1:0] op, input int unsigned f,
                          input int unsigned d, input int unsigned slot,
                          input int unsigned fin);
    pending.push_back('{op, FREQ_W'(f), DUR_W'(d), SLOT_W'(slot), SLOT_W'(fin)});
    if (op != OP_SPARE_A && op != OP_SPARE_B) cmds_made++;
    if (op == OP_WRITE) begin
      filled[SLOT_W'(slot)]     = 1'b1;
      stored_len[SLOT_W'(slot)] = DUR_W'(d);
      while (frontier < NOTE_DEPTH && filled[frontier]) frontier++;
    end
  endtask

  // Command whose other fields are don't-care: fill them with noise.
  task automatic push_bare(input logic [OP_W-1:0] op);
    push_cmd(op, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_bare(OP_TICK);
  endtask

  // Ticks for a running tone, sometimes with a mute window in the middle.
  task automatic push_play_ticks(input int n);
    int cut;
    if (n > 1 && $urandom_range(3) == 0) begin
      cut = $urandom_range(1, n - 1);
      push_ticks(cut);
      push_bare(OP_MUTE);
      push_ticks($urandom_range(1, 3));
      push_bare(OP_UNMUTE);
      push_ticks(n - cut);
    end else begin
      push_ticks(n);
    end
  endtask

  function automatic int unsigned rand_freq();
    int unsigned r;
    r = $urandom_range(19);
    if (r < 12) return $urandom_range(FREQ_MIN, FREQ_MAX);
    if (r < 14) return $urandom_range(FREQ_MIN, 600);  // long reloads
    if (r < 16) begin
      case ($urandom_range(3))
        0:       return FREQ_MIN - 1;
        1:       return FREQ_MIN;
        2:       return FREQ_MAX;
        default: return FREQ_MAX + 1;
      endcase
    end
    return $urandom_range(0, 65535);
  endfunction

  // Short notes keep sequences within a few dozen ticks.
  function automatic int unsigned rand_len(input bit stored);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return stored ? $urandom_range(0, 3) : $urandom_range(0, 6);
    if (r < 96) return $urandom_range(4, 20);
    return $urandom_range(0, 255);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 12;
      default: return 40;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers pending commands at the falling edge, holds while stalled
  // --------------------------------------------------------------------------
  int in_gap_pct = 0;
  int in_gap_left = 0;
  int in_cycles = 0;

  always @(negedge clk) begin : driver
    cmd_t c;
    if (rst_n) begin
      in_cycles++;
      if (in_cycles % 128 == 0) in_gap_pct = pick_pct();
      // a command stays on the bus until its transaction completes
      if (!in_valid || in_taken) begin
        if (in_gap_left > 0) begin
          in_gap_left--;
          in_valid <= 1'b0;
        end else if (pending.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending.size() > CALM_TAIL && hold_left == 0 &&
                     $urandom_range(99) < in_gap_pct) begin
          in_gap_left = $urandom_range(0, 8);  // start an idle burst on the input
          in_valid <= 1'b0;
        end else begin
          c = pending.pop_front();
          in_operation      <= c.op;
          in_freq_hz        <= c.freq;
          in_duration_ticks <= c.dur;
          in_note_slot      <= c.slot;
          in_final_slot     <= c.fin;
          in_valid          <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall: random bursts plus one long hold-off so the DUT backs up
  // and stalls its command input while the driver keeps offering
  // --------------------------------------------------------------------------
  int  out_stall_pct = 0;
  int  out_stall_left = 0;
  int  out_cycles = 0;
  bit  hold_done = 1'b0;

  always @(negedge clk) begin : receiver
    if (rst_n) begin
      out_cycles++;
      if (out_cycles % 128 == 64) out_stall_pct = pick_pct();
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && checked >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (out_stall_left > 0) begin
        out_stall_left--;
        out_stall <= 1'b1;
      end else if (pending.size() > CALM_TAIL && $urandom_range(99) < out_stall_pct) begin
        out_stall_left = $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: at each rising edge, check a completed status transaction against
  // the oldest prediction, then feed a completed command transaction to the model
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    status_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        checked++;
        if (status_due.size() == 0) begin
          $display("%0t: unexpected status, expected none, actual on=%0d reload=%0d cmp=%0d",
                   $time, out_tone_on, out_period_reload, out_duty_compare);
          errors++;
        end else begin
          want = status_due.pop_front();
          check_field("tone_on", want.on, out_tone_on);
          check_field("period_reload", want.reload, out_period_reload);
          check_field("duty_compare", want.compare, out_duty_compare);
          check_field("is_muted", want.muted, out_is_muted);
          check_field("play_state", want.play, out_play_state);
        end
      end
      if (in_valid && !in_stall)
        step_player('{in_operation, in_freq_hz, in_duration_ticks, in_note_slot, in_final_slot});
      in_taken <= in_valid && !in_stall;
      idle_run <= ((in_valid && !in_stall) || (out_valid && !out_stall)) ? 0 : idle_run + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int          n, i, est;
    int unsigned fin, d;
    logic [OP_W-1:0] nop;

    // Directed: idle tick, boundary frequencies, all-ones fields, rejected tone,
    // play while muted, a short sequence to its end, and the unused opcodes.
    push_bare(OP_TICK);
    push_cmd(OP_WRITE, FREQ_MIN, 2, 0, 0);
    push_cmd(OP_WRITE, FREQ_MAX, 0, 1, 0);
    push_cmd(OP_WRITE, FREQ_MIN - 1, 1, 2, 0);     // note with an ignored frequency
    push_cmd(OP_WRITE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    push_cmd(OP_SINGLE, FREQ_MAX + 1, 0, 0, 0);    // tone rejected, old PWM kept
    push_ticks(3);
    push_bare(OP_MUTE);
    push_cmd(OP_SINGLE, FREQ_MIN, 1, 0, 0);        // accepted while muted
    push_ticks(1);                                 // frozen
    push_bare(OP_UNMUTE);
    push_ticks(2);
    push_cmd(OP_SEQ, 0, 0, 0, 2);
    push_ticks(6);                                 // three notes through to idle
    push_cmd(OP_SPARE_A, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    push_cmd(OP_SPARE_B, 0, 0, 0, 0);

    // Longest single note: the count has to climb to 256.
    push_cmd(OP_SINGLE, rand_freq(), 8'hFF, $urandom, $urandom);
    push_ticks(259);

    // Random episodes: mostly complete plays, some cut short, some noise.
    while (cmds_made < STIM_ITEMS) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          // grow the written prefix, then play part of it
          n = $urandom_range(1, 4);
          repeat (n)
            if (frontier < NOTE_DEPTH)
              push_cmd(OP_WRITE, rand_freq(), rand_len(1), frontier, $urandom);
          if ($urandom_range(3) == 0)
            push_cmd(OP_WRITE, rand_freq(), rand_len(1), $urandom_range(0, frontier - 1),
                     $urandom);
          fin = ($urandom_range(7) == 0) ? $urandom_range(0, frontier - 1)
                                         : $urandom_range(0, (frontier > 7) ? 6 : frontier - 1);
          est = 3;
          for (i = 0; i <= int'(fin); i++) est += (stored_len[i] == 0) ? 1 : stored_len[i];
          if (est > 70) est = 70;
          push_cmd(OP_SEQ, $urandom, $urandom, $urandom, fin);
          push_play_ticks(($urandom_range(3) == 0) ? $urandom_range(1, est) : est);
        end
        3, 4, 5: begin
          d = rand_len(0);
          push_cmd(OP_SINGLE, rand_freq(), d, $urandom, $urandom);
          est = (d + 3 > 70) ? 70 : d + 3;
          push_play_ticks(($urandom_range(3) == 0) ? $urandom_range(1, est) : est);
        end
        6: begin
          push_bare(OP_MUTE);
          push_ticks($urandom_range(1, 4));
          if ($urandom_range(1)) push_cmd(OP_SINGLE, rand_freq(), rand_len(0), $urandom, $urandom);
          push_bare(OP_UNMUTE);
          push_ticks($urandom_range(1, 4));
        end
        default: begin
          // any opcode, any field; sequence ends stay inside the written prefix
          n = $urandom_range(3, 8);
          repeat (n) begin
            nop = OP_W'($urandom_range(0, 7));
            if (nop == OP_SEQ)
              push_cmd(nop, $urandom, $urandom, $urandom, $urandom_range(0, frontier - 1));
            else
              push_cmd(nop, $urandom, $urandom, $urandom, $urandom);
          end
        end
      endcase
    end

    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Run until every command is taken and every status is back, or the
    // watchdog sees no transaction for too long.
    do begin
      @(posedge clk);
    end while ((pending.size() != 0 || in_valid || status_due.size() != 0) &&
               idle_run < WATCHDOG);

    if (idle_run < WATCHDOG) begin
      repeat (DRAIN_CYCLES) @(posedge clk);
    end else begin
      $display("%0t: watchdog expired after %0d cycles without a transaction", $time, WATCHDOG);
      errors++;
    end
    if (status_due.size() != 0) begin
      $display("%0t: %0d predicted statuses never arrived", $time, status_due.size());
      errors += status_due.size();
    end

    $display("Ran %0d ticks, %0d single plays, %0d sequence plays, %0d note writes, %0d other",
             n_tick, n_single, n_seq, n_write, n_misc);
    $display("Checked %0d statuses; note store written through slot %0d; one %0d-cycle hold-off",
             checked, frontier - 1, HOLD_CYCLES);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ buzzer_tone_sequencer.f @@
+incdir+hw/rtl
hw/rtl/bts_pkg.sv
hw/rtl/bts_ram.sv
hw/rtl/bts_div.sv
hw/rtl/buzzer_tone_sequencer.sv
sim/tb.sv
